/* src/urbe_pkg.sv */
// ----------------------------------------------------------------------------
// urbe_pkg
// Shared types and codes for the UART ring-buffer endpoint.
// ----------------------------------------------------------------------------
package urbe_pkg;

    localparam int URBE_DEPTH = 64;

    localparam logic [2:0] ACT_LINE_RX = 3'd0;
    localparam logic [2:0] ACT_GET     = 3'd1;
    localparam logic [2:0] ACT_PEEK    = 3'd2;
    localparam logic [2:0] ACT_SEND    = 3'd3;
    localparam logic [2:0] ACT_TX_DONE = 3'd4;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
    } urbe_req_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [6:0] rx_level;
        logic       tx_load;
        logic [7:0] tx_byte;
        logic       tx_idle;
    } urbe_rsp_t;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic execute;
    } urbe_cmd_t;

    typedef struct packed {
        logic clear_last;
    } urbe_status_t;

endpackage

/* src/uart_ring_buffer_endpoint_top.sv */
// ----------------------------------------------------------------------------
// uart_ring_buffer_endpoint_top
// Buffered UART endpoint: receive ring and transmit ring, DEPTH bytes each.
//
// Request channel (req_valid / req_stall / req) carries one word per action:
// line byte in, host get, host peek, host send, transmit done.
// Response channel (rsp_valid / rsp_stall / rsp) returns one word per request
// with the read byte, receive level, transmitter load and idle flags.
// Each request is handled in order: capture with the ring read issued, then
// execute on the registered RAM data. rsp_valid is set by the execute step,
// and no new word is taken while a request is still executing.
// The response register frees the request side: a new word is taken while
// a response is being accepted. If rsp_stall holds, the finished response
// stays put and req_stall is raised until it is taken.
// After reset every address of the receive store is swept to zero, with
// req_stall high throughout; both rings start empty and the transmitter idle.
// ----------------------------------------------------------------------------
module uart_ring_buffer_endpoint_top
    import urbe_pkg::*;
#(
    parameter int DEPTH = URBE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  urbe_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output urbe_rsp_t rsp
);

    urbe_cmd_t    cmd;
    urbe_status_t status;

    urbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .status    (status)
    );

    urbe_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .req    (req),
        .rsp    (rsp)
    );

endmodule

/* src/urbe_ram.sv */
// ----------------------------------------------------------------------------
// urbe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module urbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/urbe_ctrl.sv */
// ----------------------------------------------------------------------------
// urbe_ctrl
// Sequencer: receive-store clear sweep, word capture, execute, response valid.
// ----------------------------------------------------------------------------
module urbe_ctrl
    import urbe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_stall,
    output logic         rsp_valid,
    input  logic         rsp_stall,
    output urbe_cmd_t    cmd,
    input  urbe_status_t status
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign req_stall = !((state_reg == ST_IDLE) && (!out_valid_reg || !rsp_stall));
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = out_valid_reg;

    assign cmd.clear_wr = (state_reg == ST_CLEAR);
    assign cmd.capture  = accept;
    assign cmd.execute  = (state_reg == ST_EXEC);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/urbe_dp.sv */
// ----------------------------------------------------------------------------
// urbe_dp
// Datapath: receive and transmit rings, pointers, levels, response register.
// ----------------------------------------------------------------------------
module urbe_dp
    import urbe_pkg::*;
#(
    parameter int DEPTH = URBE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  urbe_cmd_t    cmd,
    output urbe_status_t status,
    input  urbe_req_t    req,
    output urbe_rsp_t    rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

    logic [AW-1:0] clr_reg;
    logic [AW-1:0] rx_head_reg, rx_head_next;
    logic [AW-1:0] rx_tail_reg, rx_tail_next;
    logic [FW-1:0] rx_fill_reg, rx_fill_next;
    logic [AW-1:0] tx_head_reg, tx_head_next;
    logic [AW-1:0] tx_tail_reg, tx_tail_next;
    logic [FW-1:0] tx_fill_reg, tx_fill_next;
    logic          tx_stalled_reg, tx_stalled_next;
    logic [2:0]    act_reg;
    logic [7:0]    data_reg;
    urbe_rsp_t     rsp_reg;
    urbe_rsp_t     rsp_next;

    logic          rx_we;
    logic [AW-1:0] rx_waddr;
    logic [7:0]    rx_wdata;
    logic [7:0]    rx_rdata;
    logic          tx_we;
    logic [7:0]    tx_rdata;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        wrap_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign status.clear_last = (clr_reg == PTR_LAST);

    // receive store: zero sweep after reset, then line writes
    assign rx_we    = cmd.clear_wr || (cmd.capture && (req.action == ACT_LINE_RX));
    assign rx_waddr = cmd.clear_wr ? clr_reg : rx_head_reg;
    assign rx_wdata = cmd.clear_wr ? 8'd0 : req.data_byte;
    assign tx_we    = cmd.capture && (req.action == ACT_SEND);

    urbe_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (rx_wdata),
        .raddr (rx_tail_reg),
        .rdata (rx_rdata)
    );

    urbe_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_head_reg),
        .wdata (req.data_byte),
        .raddr (tx_tail_reg),
        .rdata (tx_rdata)
    );

    always_comb
    begin
        rx_head_next    = rx_head_reg;
        rx_tail_next    = rx_tail_reg;
        rx_fill_next    = rx_fill_reg;
        tx_head_next    = tx_head_reg;
        tx_tail_next    = tx_tail_reg;
        tx_fill_next    = tx_fill_reg;
        tx_stalled_next = tx_stalled_reg;
        rsp_next        = '0;

        case (act_reg)
            ACT_LINE_RX:
            begin
                rx_head_next = wrap_inc(rx_head_reg);
                if (rx_fill_reg != FILL_MAX)
                begin
                    rx_fill_next = rx_fill_reg + 1'b1;
                end
                else
                begin
                    rx_tail_next = wrap_inc(rx_tail_reg);
                end
            end
            ACT_GET:
            begin
                if (rx_fill_reg != '0)
                begin
                    rsp_next.read_byte = rx_rdata;
                    rx_tail_next       = wrap_inc(rx_tail_reg);
                    rx_fill_next       = rx_fill_reg - 1'b1;
                end
            end
            ACT_PEEK:
            begin
                rsp_next.read_byte = rx_rdata;
            end
            ACT_SEND:
            begin
                tx_head_next = wrap_inc(tx_head_reg);
                if (tx_stalled_reg)
                begin
                    // idle transmitter implies an empty ring: byte passes straight out
                    tx_tail_next     = wrap_inc(tx_tail_reg);
                    tx_stalled_next  = 1'b0;
                    rsp_next.tx_load = 1'b1;
                    rsp_next.tx_byte = data_reg;
                end
                else if (tx_fill_reg != FILL_MAX)
                begin
                    tx_fill_next = tx_fill_reg + 1'b1;
                end
                else
                begin
                    tx_tail_next = wrap_inc(tx_tail_reg);
                end
            end
            ACT_TX_DONE:
            begin
                if (tx_fill_reg != '0)
                begin
                    tx_tail_next     = wrap_inc(tx_tail_reg);
                    tx_fill_next     = tx_fill_reg - 1'b1;
                    rsp_next.tx_load = 1'b1;
                    rsp_next.tx_byte = tx_rdata;
                end
                else
                begin
                    tx_stalled_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        rsp_next.rx_level = 7'(rx_fill_next);
        rsp_next.tx_idle  = tx_stalled_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg        <= '0;
            rx_head_reg    <= '0;
            rx_tail_reg    <= '0;
            rx_fill_reg    <= '0;
            tx_head_reg    <= '0;
            tx_tail_reg    <= '0;
            tx_fill_reg    <= '0;
            tx_stalled_reg <= 1'b1;
        end
        else
        begin
            if (cmd.clear_wr && !status.clear_last)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.execute)
            begin
                rx_head_reg    <= rx_head_next;
                rx_tail_reg    <= rx_tail_next;
                rx_fill_reg    <= rx_fill_next;
                tx_head_reg    <= tx_head_next;
                tx_tail_reg    <= tx_tail_next;
                tx_fill_reg    <= tx_fill_next;
                tx_stalled_reg <= tx_stalled_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= req.action;
            data_reg <= req.data_byte;
        end
        if (cmd.execute)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

/* bench/urbe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urbe_checker
// Watches the request and response channels of the UART ring-buffer
// endpoint. It models both rings and the transmitter state for every
// accepted request word, queues the expected response and compares each
// accepted response word field by field with the oldest entry. The mismatch
// count and the number of responses still owed go back to the bench top.
// ----------------------------------------------------------------------------
module urbe_checker
    import urbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  urbe_req_t req,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  urbe_rsp_t rsp,
    output int        fail_count,
    output int        pending
);

    localparam int PTR_W = $clog2(URBE_DEPTH);

    logic [7:0]       rx_mem [URBE_DEPTH];
    logic [7:0]       tx_mem [URBE_DEPTH];
    logic [PTR_W-1:0] rx_head, rx_tail, tx_head, tx_tail;
    logic [6:0]       rx_fill, tx_fill;
    logic             tx_waiting;

    urbe_rsp_t        owed_rsp_q[$];
    int               mismatch_count = 0;

    assign fail_count = mismatch_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(URBE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    task automatic clear_rings();
        for (int i = 0; i < URBE_DEPTH; i++)
        begin
            rx_mem[i] = '0;
            tx_mem[i] = '0;
        end
        rx_head    = '0;
        rx_tail    = '0;
        rx_fill    = '0;
        tx_head    = '0;
        tx_tail    = '0;
        tx_fill    = '0;
        tx_waiting = 1'b1;
    endtask

    // one request word -> the response the endpoint owes for it
    task automatic step_endpoint(input urbe_req_t w, output urbe_rsp_t r);
        r = '0;
        case (w.action)
            ACT_LINE_RX:
            begin
                rx_mem[rx_head] = w.data_byte;
                rx_head = next_ptr(rx_head);
                if (rx_fill < 7'(URBE_DEPTH))
                    rx_fill = rx_fill + 1'b1;
                else
                    rx_tail = next_ptr(rx_tail);
            end
            ACT_GET:
            begin
                if (rx_fill != '0)
                begin
                    r.read_byte = rx_mem[rx_tail];
                    rx_tail = next_ptr(rx_tail);
                    rx_fill = rx_fill - 1'b1;
                end
            end
            ACT_PEEK:
                r.read_byte = rx_mem[rx_tail];
            ACT_SEND:
            begin
                tx_mem[tx_head] = w.data_byte;
                tx_head = next_ptr(tx_head);
                if (tx_fill < 7'(URBE_DEPTH))
                    tx_fill = tx_fill + 1'b1;
                else
                    tx_tail = next_ptr(tx_tail);
                if (tx_waiting)
                begin
                    tx_waiting = 1'b0;
                    r.tx_load = 1'b1;
                    r.tx_byte = tx_mem[tx_tail];
                    tx_tail = next_ptr(tx_tail);
                    tx_fill = tx_fill - 1'b1;
                end
            end
            ACT_TX_DONE:
            begin
                if (tx_fill != '0)
                begin
                    r.tx_load = 1'b1;
                    r.tx_byte = tx_mem[tx_tail];
                    tx_tail = next_ptr(tx_tail);
                    tx_fill = tx_fill - 1'b1;
                end
                else
                    tx_waiting = 1'b1;
            end
            default: ;
        endcase
        r.rx_level = rx_fill;
        r.tx_idle  = tx_waiting;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        urbe_rsp_t want;
        urbe_rsp_t got;
        if (!rst_n)
        begin
            clear_rings();
            owed_rsp_q.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                got = rsp;
                if (owed_rsp_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] response word with none owed: rd=%02h lvl=%0d",
                                 $realtime, got.read_byte, got.rx_level);
                end
                else
                begin
                    want = owed_rsp_q.pop_front();
                    if (got.read_byte !== want.read_byte || got.rx_level !== want.rx_level ||
                        got.tx_load !== want.tx_load || got.tx_byte !== want.tx_byte ||
                        got.tx_idle !== want.tx_idle)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("[%0t] exp %02h/%0d/%b/%02h/%b got %02h/%0d/%b/%02h/%b",
                                     $realtime, want.read_byte, want.rx_level, want.tx_load,
                                     want.tx_byte, want.tx_idle, got.read_byte, got.rx_level,
                                     got.tx_load, got.tx_byte, got.tx_idle);
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                step_endpoint(req, want);
                owed_rsp_q.push_back(want);
            end
            pending <= owed_rsp_q.size();
        end
    end

endmodule

/* bench/tb_uart_ring_buffer_endpoint_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_ring_buffer_endpoint_top
// Bench for the UART ring-buffer endpoint. A short directed run covers the
// empty corners of both rings, peek of a stale byte, transmit done
// while idle and the unused action codes. Random segments follow: floods
// that overrun either ring, drains, mixed traffic and noise. The sender
// works in bursts with gaps and the receiver stalls in changing patterns;
// the checker beside the block predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_uart_ring_buffer_endpoint_top
    import urbe_pkg::*;
();

    localparam logic [2:0] ACT_SPARE_5 = 3'd5;
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    localparam int         RANDOM_WORDS = 550;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCK} stall_mode_e;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    urbe_req_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    urbe_rsp_t rsp;

    int        fail_count;
    int        pending;

    urbe_req_t   stim_q[$];
    stall_mode_e stall_mode = STALL_NONE;
    int          mode_left  = 0;

    logic [2:0] live_ops [5] = '{ACT_LINE_RX, ACT_GET, ACT_PEEK, ACT_SEND, ACT_TX_DONE};
    logic [2:0] spare_ops[3] = '{ACT_SPARE_5, ACT_SPARE_6, ACT_SPARE_7};

    uart_ring_buffer_endpoint_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    urbe_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #4 clk = ~clk;

    // response side back-pressure
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= stall_mode_e'($urandom_range(0, 3));
            mode_left  <= $urandom_range(16, 96);
            rsp_stall  <= 1'b0;
        end
        else
        begin
            mode_left <= mode_left - 1;
            case (stall_mode)
                STALL_NONE:  rsp_stall <= 1'b0;
                STALL_LIGHT: rsp_stall <= ($urandom_range(0, 7) == 0);
                STALL_HEAVY: rsp_stall <= $urandom_range(0, 1);
                default:     rsp_stall <= ((mode_left % 12) < 8);
            endcase
        end
    end

    task automatic add_word(input logic [2:0] action, input logic [7:0] data_byte);
        urbe_req_t w;
        w.action    = action;
        w.data_byte = data_byte;
        stim_q.push_back(w);
    endtask

    task automatic drive_words();
        int burst;
        int gap;
        while (stim_q.size() > 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && stim_q.size() > 0)
            begin
                req       <= stim_q.pop_front();
                req_valid <= 1'b1;
                do @(posedge clk); while (req_stall);
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 && stim_q.size() > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic hold_until_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int seg_len;
        int live_count;
        logic [2:0] op;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        add_word(ACT_PEEK,    8'h00);   // peek after reset
        add_word(ACT_GET,     8'hff);   // get on empty ring
        add_word(ACT_TX_DONE, 8'h00);   // done while already idle
        add_word(ACT_SPARE_5, 8'hff);
        add_word(ACT_LINE_RX, 8'h00);
        add_word(ACT_LINE_RX, 8'hff);
        add_word(ACT_PEEK,    8'h55);
        add_word(ACT_GET,     8'h00);
        add_word(ACT_GET,     8'h00);
        add_word(ACT_GET,     8'h00);
        add_word(ACT_LINE_RX, 8'h7f);
        add_word(ACT_GET,     8'h00);
        add_word(ACT_PEEK,    8'h00);   // stale byte on empty ring
        add_word(ACT_SEND,    8'ha5);   // idle transmitter loads at once
        add_word(ACT_SEND,    8'h5a);
        add_word(ACT_SEND,    8'hff);
        add_word(ACT_TX_DONE, 8'hff);
        add_word(ACT_TX_DONE, 8'h00);
        add_word(ACT_TX_DONE, 8'h00);   // ring empty, goes idle
        add_word(ACT_TX_DONE, 8'h00);
        add_word(ACT_SEND,    8'h00);
        add_word(ACT_SPARE_6, 8'h80);
        add_word(ACT_SPARE_7, 8'h01);
        add_word(ACT_LINE_RX, 8'h80);
        add_word(ACT_GET,     8'h00);
        drive_words();
        hold_until_drained();

        live_count = 0;
        while (live_count < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    seg_len = $urandom_range(8, 80);
                    repeat (seg_len) add_word(ACT_LINE_RX, 8'($urandom));
                    live_count += seg_len;
                end
                2:
                begin
                    seg_len = $urandom_range(4, 70);
                    repeat (seg_len)
                        add_word(($urandom_range(0, 5) == 0) ? ACT_PEEK : ACT_GET,
                                 8'($urandom));
                    live_count += seg_len;
                end
                3:
                begin
                    seg_len = $urandom_range(8, 80);
                    repeat (seg_len) add_word(ACT_SEND, 8'($urandom));
                    live_count += seg_len;
                end
                4:
                begin
                    seg_len = $urandom_range(4, 70);
                    repeat (seg_len) add_word(ACT_TX_DONE, 8'($urandom));
                    live_count += seg_len;
                end
                9:
                begin
                    seg_len = $urandom_range(5, 15);
                    repeat (seg_len)
                    begin
                        op = ($urandom_range(0, 1) == 0) ? live_ops[$urandom_range(0, 4)]
                                                         : spare_ops[$urandom_range(0, 2)];
                        add_word(op, 8'($urandom));
                    end
                end
                default:
                begin
                    seg_len = $urandom_range(10, 40);
                    repeat (seg_len)
                    begin
                        if ($urandom_range(0, 15) == 0)
                            op = spare_ops[$urandom_range(0, 2)];
                        else
                        begin
                            op = live_ops[$urandom_range(0, 4)];
                            live_count++;
                        end
                        add_word(op, 8'($urandom));
                    end
                end
            endcase
            drive_words();
            if ($urandom_range(0, 5) == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
src/urbe_pkg.sv
src/urbe_ram.sv
src/urbe_ctrl.sv
src/urbe_dp.sv
src/uart_ring_buffer_endpoint_top.sv
bench/urbe_checker.sv
bench/tb_uart_ring_buffer_endpoint_top.sv
